/* sv/cbs_pkg.sv */
// cbs_pkg: shared types, command codes and constants for the cell balance selector
// used by every module of the cell balance selector except cbs_checker; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

	// cell stack geometry and field widths
	localparam int NumCells   = 4;
	localparam int VoltW      = 24;
	localparam int GainW      = 9;
	localparam int OffsetW    = 8;
	localparam int ThreshW    = 23;
	localparam int RawW       = 14;
	localparam int CellIdxW   = 2;
	localparam int MaskW      = NumCells;

	// offset trim is given in millivolts
	localparam int OffsetScale = 1000;

	// lowest-cell search starts at 4.2 V
	localparam logic signed [VoltW-1:0] MinStartUv = 24'sd4200000;
	localparam logic signed [VoltW-1:0] VoltMax    = 24'sh7FFFFF;
	localparam logic signed [VoltW-1:0] VoltMin    = 24'sh800000;

	// register reset values
	localparam logic [GainW-1:0]          GainReset   = 9'd380;
	localparam logic signed [OffsetW-1:0] OffsetReset = 8'sd0;
	localparam logic [ThreshW-1:0]        ThreshReset = 23'd20000;

	// command carried in tuser
	typedef enum logic [1:0] {
		CmdSample  = 2'd0,
		CmdBalance = 2'd1,
		CmdDisable = 2'd2
	} cmd_t;

	// register index, byte address divided by four
	typedef enum logic [1:0] {
		RegGain   = 2'd0,
		RegOffset = 2'd1,
		RegThresh = 2'd2
	} reg_idx_t;

	typedef logic signed [VoltW-1:0] volt_t;
	typedef volt_t [NumCells-1:0] volt_arr_t;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [GainW-1:0]          gain;
		logic signed [OffsetW-1:0] offset;
		logic [ThreshW-1:0]        threshold;
	} cfg_t;

endpackage

`default_nettype wire

/* sv/cbs_regs.sv */
// cbs_regs: APB configuration registers (gain, offset, balance threshold)
// depends on cbs_pkg for the register indexes, reset values and cfg_t
`timescale 1ns / 1ps
`default_nettype none

module cbs_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cbs_pkg::cfg_t    cfg
);

	cbs_pkg::cfg_t      cfg_q;
	cbs_pkg::reg_idx_t  reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = cbs_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain      <= cbs_pkg::GainReset;
			cfg_q.offset    <= cbs_pkg::OffsetReset;
			cfg_q.threshold <= cbs_pkg::ThreshReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				cbs_pkg::RegGain:   cfg_q.gain      <= pwdata[cbs_pkg::GainW-1:0];
				cbs_pkg::RegOffset: cfg_q.offset    <= pwdata[cbs_pkg::OffsetW-1:0];
				cbs_pkg::RegThresh: cfg_q.threshold <= pwdata[cbs_pkg::ThreshW-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			cbs_pkg::RegGain:   prdata = 32'(cfg_q.gain);
			cbs_pkg::RegOffset: prdata = 32'(cfg_q.offset);
			cbs_pkg::RegThresh: prdata = 32'(cfg_q.threshold);
			default:            prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* sv/cbs_convert.sv */
// cbs_convert: raw ADC code to microvolts, gain * raw + offset * 1000, saturated
// depends on cbs_pkg for widths and limits
`timescale 1ns / 1ps
`default_nettype none

module cbs_convert (
	input  wire logic [cbs_pkg::RawW-1:0]           raw_code,
	input  wire logic [cbs_pkg::GainW-1:0]          gain,
	input  wire logic signed [cbs_pkg::OffsetW-1:0] offset,
	output cbs_pkg::volt_t                          volt
);

	localparam int ProdW = cbs_pkg::GainW + cbs_pkg::RawW;
	localparam int OfsW  = 18;
	localparam int SumW  = cbs_pkg::VoltW + 1;

	logic [ProdW-1:0]       prod;
	logic signed [OfsW-1:0] ofs_uv;
	logic signed [SumW-1:0] sum;

	// one multiply plus a constant scale of the offset trim
	assign prod   = ProdW'(gain) * ProdW'(raw_code);
	assign ofs_uv = OfsW'(offset) * OfsW'(signed'(cbs_pkg::OffsetScale));
	assign sum    = signed'(SumW'(prod)) + SumW'(ofs_uv);

	// clamp to the 24-bit signed range
	always_comb begin
		if (sum[SumW-1] != sum[SumW-2]) begin
			volt = sum[SumW-1] ? cbs_pkg::VoltMin : cbs_pkg::VoltMax;
		end else begin
			volt = sum[SumW-2:0];
		end
	end

endmodule

`default_nettype wire

/* sv/cbs_select.sv */
// cbs_select: lowest-cell search and greedy non-adjacent bleed mask
// depends on cbs_pkg for the voltage array type and constants
`timescale 1ns / 1ps
`default_nettype none

module cbs_select (
	input  wire cbs_pkg::volt_arr_t          volts,
	input  wire logic [cbs_pkg::ThreshW-1:0] threshold,
	output logic [cbs_pkg::MaskW-1:0]        mask,
	output logic                             all_measured
);

	localparam int ExW = cbs_pkg::VoltW + 1;

	cbs_pkg::volt_t             lowest;
	logic signed [ExW-1:0]      excess [cbs_pkg::NumCells];
	logic [cbs_pkg::MaskW-1:0]  cand;

	// minimum over the stack, never above the 4.2 V start
	always_comb begin
		lowest = cbs_pkg::MinStartUv;
		for (int i = 0; i < cbs_pkg::NumCells; i++) begin
			if (volts[i] < lowest) begin
				lowest = volts[i];
			end
		end
	end

	// per-cell excess check against the threshold
	always_comb begin
		for (int i = 0; i < cbs_pkg::NumCells; i++) begin
			excess[i] = ExW'(volts[i]) - ExW'(lowest);
			cand[i]   = excess[i] >= signed'(ExW'(threshold));
		end
	end

	// greedy scan from cell 0 up, skip a cell whose lower neighbor is marked
	always_comb begin
		mask = '0;
		for (int i = 0; i < cbs_pkg::NumCells; i++) begin
			if (i == 0) begin
				mask[i] = cand[i];
			end else begin
				mask[i] = cand[i] & ~mask[i-1];
			end
		end
	end

	// every cell needs a nonzero reading before balancing
	always_comb begin
		all_measured = 1'b1;
		for (int i = 0; i < cbs_pkg::NumCells; i++) begin
			if (volts[i] == '0) begin
				all_measured = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/cell_balance_selector_core.sv */
// cell_balance_selector_core: four-cell passive balancing decision, stream in and out
// path: an accepted transaction passes the input register, then the result register
// throughput: one transaction per cycle, both registers flow, unless output stalls
// reset: arst_n clears valid flags, stored cell voltages and configuration registers
// depends on cbs_pkg, cbs_regs, cbs_convert and cbs_select
`timescale 1ns / 1ps
`default_nettype none

module cell_balance_selector_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [1:0] cell_index, [15:2] raw_code
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [23:0] cell_voltage_uv, [27:24] balance_mask
	output logic [0:0]       m_axis_tuser,  // [0] mask_write
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cbs_pkg::cfg_t                      cfg;
	cbs_pkg::cmd_t                      cmd_s1;
	logic [cbs_pkg::CellIdxW-1:0]       cell_index_s1;
	logic [cbs_pkg::RawW-1:0]           raw_code_s1;
	logic                               valid_s1;
	logic                               adv_s1;
	cbs_pkg::volt_arr_t                 cell_volts_q;
	cbs_pkg::volt_t                     conv_volt;
	logic [cbs_pkg::MaskW-1:0]          sel_mask;
	logic                               all_measured;
	cbs_pkg::volt_t                     res_volt;
	logic [cbs_pkg::MaskW-1:0]          res_mask;
	logic                               res_write;
	logic                               valid_s2;
	cbs_pkg::volt_t                     volt_s2;
	logic [cbs_pkg::MaskW-1:0]          mask_s2;
	logic                               write_s2;

	cbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: stage 1 moves on whenever the result register is free or drained
	assign adv_s1        = ~valid_s2 | m_axis_tready;
	assign s_axis_tready = ~valid_s1 | adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1        <= cbs_pkg::cmd_t'(s_axis_tuser);
			cell_index_s1 <= s_axis_tdata[1:0];
			raw_code_s1   <= s_axis_tdata[15:2];
		end
	end

	cbs_convert u_convert (
		.raw_code (raw_code_s1),
		.gain     (cfg.gain),
		.offset   (cfg.offset),
		.volt     (conv_volt)
	);

	cbs_select u_select (
		.volts        (cell_volts_q),
		.threshold    (cfg.threshold),
		.mask         (sel_mask),
		.all_measured (all_measured)
	);

	// per-cell voltage store, written as a sample leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_volts_q <= '0;
		end else if (valid_s1 && adv_s1 && cmd_s1 == cbs_pkg::CmdSample) begin
			cell_volts_q[cell_index_s1] <= conv_volt;
		end
	end

	// result fields per command
	always_comb begin
		res_volt  = '0;
		res_mask  = '0;
		res_write = 1'b0;
		case (cmd_s1)
			cbs_pkg::CmdSample: begin
				res_volt = conv_volt;
			end
			cbs_pkg::CmdBalance: begin
				res_mask  = all_measured ? sel_mask : '0;
				res_write = all_measured;
			end
			cbs_pkg::CmdDisable: begin
				res_write = 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			volt_s2  <= res_volt;
			mask_s2  <= res_mask;
			write_s2 <= res_write;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, mask_s2, volt_s2};
	assign m_axis_tuser  = write_s2;

endmodule

`default_nettype wire

/* sv/cbs_checker.sv */
// cbs_checker: port-level checks on the result stream of the balance selector
// bound to cell_balance_selector_core; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

module cbs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);

	// a stalled result transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// no two neighboring cells bleed at once
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[27:24] & {1'b0, m_axis_tdata[27:25]}) == 4'd0)
		else $error("adjacent cells marked for bleeding");

	// a mask is only carried on a mask write
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[27:24] == 4'd0)
		else $error("mask set without mask write");

	// mask writes carry no voltage and padding stays clear
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:0] == 24'd0
			&& m_axis_tdata[31:28] == 4'd0)
		else $error("voltage or padding set on mask write");

endmodule

bind cell_balance_selector_core cbs_checker u_cbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
